// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hit time histogram peak finder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/htpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram peak finder package
// Types, register indexes and fixed widths shared by all modules of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package htpf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_START      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_USED       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MIN_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MASK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MASK   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_MASK = 3'd7;

  localparam int TIME_IN_W  = 16;
  localparam int WIDTH_W    = 12;
  localparam int BINS_W     = 7;
  localparam int LEVEL_W    = 12;
  localparam int FLAGS_W    = 32;
  localparam int BIN_OUT_W  = 6;
  localparam int TIME_OUT_W = 19;
  localparam int HEIGHT_W   = 12;

  localparam int MAX_RESULTS = 64;
  localparam int RES_BITS    = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  localparam logic [TIME_IN_W-1:0] RST_TIME_START      = 16'd500;
  localparam logic [WIDTH_W-1:0]   RST_BIN_WIDTH       = 12'd20;
  localparam logic [BINS_W-1:0]    RST_BINS_USED       = 7'd60;
  localparam logic [LEVEL_W-1:0]   RST_RUN_THRESHOLD   = 12'd5;
  localparam logic [LEVEL_W-1:0]   RST_PEAK_MIN_HEIGHT = 12'd8;

  typedef struct packed {
    logic [TIME_IN_W-1:0] time_start;
    logic [WIDTH_W-1:0]   bin_width;
    logic [LEVEL_W-1:0]   run_threshold;
    logic [LEVEL_W-1:0]   peak_min_height;
    logic [FLAGS_W-1:0]   required_mask;
    logic [FLAGS_W-1:0]   position_mask;
    logic [FLAGS_W-1:0]   background_mask;
  } cfg_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_CHECK,
    FS_RANGE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_INC,
    BS_READ,
    BS_DIFF,
    BS_SQUARE,
    BS_DECIDE,
    BS_TAIL,
    BS_FINISH
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/htpf_queue.sv =====
// ----------------------------------------------------------------------------
// Histogram peak finder queue
// Short first-in first-out buffer between the classifying front end and the
// histogram back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module htpf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] entries [htpf_pkg::QUEUE_DEPTH];
  logic [htpf_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [htpf_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [htpf_pkg::QCNT_BITS-1:0] count;

  assign full     = count == htpf_pkg::QCNT_BITS'(htpf_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + htpf_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + htpf_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + htpf_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - htpf_pkg::QCNT_BITS'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= htpf_pkg::QCNT_BITS'(htpf_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== rtl/htpf_front.sv =====
// ----------------------------------------------------------------------------
// Histogram peak finder front end
// Accepts hits, applies the flag selection and the time window, and finds the
// bin index with a two-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module htpf_front #(
  parameter int MAX_BINS = 64,
  localparam int IDX_BITS = $clog2(MAX_BINS),
  localparam int NB = $clog2(MAX_BINS + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  htpf_pkg::cfg_t                       cfg,
  input  logic [NB-1:0]                        n_eff,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [htpf_pkg::TIME_IN_W-1:0]       hit_time,
  input  logic [htpf_pkg::FLAGS_W-1:0]         hit_flags,
  input  logic                                 hit_present,
  input  logic                                 last_hit,
  output logic                                 q_push,
  output logic [IDX_BITS+1:0]                  q_data,
  input  logic                                 q_full
);

  localparam int QB  = ((IDX_BITS + 1) / 2) * 2;
  localparam int CW  = QB + htpf_pkg::TIME_IN_W;
  localparam int PW  = NB + htpf_pkg::WIDTH_W;
  localparam int LW  = (PW > htpf_pkg::TIME_IN_W) ? PW : htpf_pkg::TIME_IN_W;
  localparam int DCW = $clog2(QB);
  localparam int AW  = QB + NB;

  htpf_pkg::front_state_t state;
  htpf_pkg::front_state_t state_next;

  logic [htpf_pkg::TIME_IN_W-1:0] time_q;
  logic [htpf_pkg::FLAGS_W-1:0]   flags_q;
  logic                           present_q;
  logic                           last_q;
  logic                           sel_q;
  logic [htpf_pkg::TIME_IN_W-1:0] diff_q;
  logic [PW-1:0]                  limit_q;
  logic [CW-1:0]                  rem;
  logic [CW-1:0]                  dvs;
  logic [QB-1:0]                  quo;
  logic [DCW-1:0]                 dcnt;
  logic                           hit_ok;

  logic          selected;
  logic          in_range;
  logic          b1;
  logic          b0;
  logic [CW-1:0] rem1;
  logic [CW-1:0] rem2;
  logic [CW-1:0] dvs_half;

  always_comb begin
    selected = ((flags_q & cfg.required_mask) == cfg.required_mask) &&
               ((flags_q & cfg.position_mask) != '0) &&
               ((flags_q & cfg.background_mask) == '0);
    in_range = LW'(diff_q) < LW'(limit_q);
    dvs_half = dvs >> 1;
    b1       = rem >= dvs;
    rem1     = b1 ? (rem - dvs) : rem;
    b0       = rem1 >= dvs_half;
    rem2     = b0 ? (rem1 - dvs_half) : rem1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htpf_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      htpf_pkg::FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = htpf_pkg::FS_CHECK;
        end
      end
      htpf_pkg::FS_CHECK: begin
        state_next = htpf_pkg::FS_RANGE;
      end
      htpf_pkg::FS_RANGE: begin
        if (sel_q && in_range) begin
          state_next = htpf_pkg::FS_DIV;
        end else if (last_q) begin
          state_next = htpf_pkg::FS_PUSH;
        end else begin
          state_next = htpf_pkg::FS_IDLE;
        end
      end
      htpf_pkg::FS_DIV: begin
        if (dcnt == '0) begin
          state_next = htpf_pkg::FS_PUSH;
        end
      end
      htpf_pkg::FS_PUSH: begin
        q_push = !q_full;
        if (!q_full) begin
          state_next = htpf_pkg::FS_IDLE;
        end
      end
      default: begin
        state_next = htpf_pkg::FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      htpf_pkg::FS_IDLE: begin
        time_q    <= hit_time;
        flags_q   <= hit_flags;
        present_q <= hit_present;
        last_q    <= last_hit;
      end
      htpf_pkg::FS_CHECK: begin
        sel_q   <= present_q && selected && (cfg.bin_width != '0) &&
                   (time_q >= cfg.time_start);
        diff_q  <= time_q - cfg.time_start;
        limit_q <= PW'(n_eff) * PW'(cfg.bin_width);
      end
      htpf_pkg::FS_RANGE: begin
        hit_ok <= sel_q && in_range;
        rem    <= CW'(diff_q);
        dvs    <= CW'(cfg.bin_width) << (QB - 1);
        quo    <= '0;
        dcnt   <= DCW'(QB / 2 - 1);
      end
      htpf_pkg::FS_DIV: begin
        rem  <= rem2;
        dvs  <= dvs >> 2;
        quo  <= QB'({quo, b1, b0});
        dcnt <= dcnt - DCW'(1);
      end
      default: begin
      end
    endcase
  end

  assign q_data = {hit_ok, last_q, quo[IDX_BITS-1:0]};

  `ASSERT_IMPLY(a_bin_in_use, clk, rst, (state == htpf_pkg::FS_PUSH) && hit_ok, AW'(quo) < AW'(n_eff))

endmodule

`default_nettype wire

// ===== rtl/htpf_back.sv =====
// ----------------------------------------------------------------------------
// Histogram peak finder back end
// Holds the histogram, adds counted hits with saturation, scans for peak runs
// at the end of an event, reports the peaks and clears the histogram.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module htpf_back #(
  parameter int MAX_BINS = 64,
  parameter int COUNT_BITS = 12,
  localparam int IDX_BITS = $clog2(MAX_BINS),
  localparam int NB = $clog2(MAX_BINS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  htpf_pkg::cfg_t                    cfg,
  input  logic [NB-1:0]                     n_eff,
  input  logic                              q_empty,
  input  logic [IDX_BITS+1:0]               q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              peak_valid,
  output logic [htpf_pkg::BIN_OUT_W-1:0]    peak_bin,
  output logic [htpf_pkg::TIME_OUT_W-1:0]   peak_time,
  output logic [htpf_pkg::HEIGHT_W-1:0]     peak_height,
  output logic                              last_peak
);

  localparam int TW = (COUNT_BITS > htpf_pkg::LEVEL_W) ? COUNT_BITS : htpf_pkg::LEVEL_W;
  localparam int SW = 2 * COUNT_BITS;
  localparam int RB = htpf_pkg::RES_BITS;
  localparam int OT = htpf_pkg::TIME_OUT_W;

  htpf_pkg::back_state_t state;
  htpf_pkg::back_state_t state_next;
  htpf_pkg::back_state_t scan_first;

  logic [COUNT_BITS-1:0] hist [MAX_BINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  mem_we;
  logic [IDX_BITS-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [IDX_BITS-1:0]   mem_raddr;

  logic [IDX_BITS-1:0]   clr_idx;
  logic [IDX_BITS-1:0]   cur_bin;
  logic                  cur_last;
  logic [IDX_BITS-1:0]   j;
  logic [OT-1:0]         bin_time;
  logic [COUNT_BITS-1:0] y;
  logic                  y_ge;
  logic [COUNT_BITS-1:0] d;
  logic                  gt;
  logic                  lt;
  logic [SW-1:0]         sq;
  logic                  in_run;
  logic [COUNT_BITS-1:0] run_max;
  logic [IDX_BITS-1:0]   run_max_bin;
  logic [OT-1:0]         run_max_time;
  logic [COUNT_BITS-1:0] prev;
  logic                  fall;
  logic [RB-1:0]         found;
  logic                  pend_valid;
  logic [htpf_pkg::BIN_OUT_W-1:0] pend_bin;
  logic [OT-1:0]                  pend_time;
  logic [htpf_pkg::HEIGHT_W-1:0]  pend_h;

  logic q_hit;
  logic q_last;
  logic [IDX_BITS-1:0] q_bin;
  logic fall_t;
  logic rise_t;
  logic fall_n;
  logic split;
  logic end_run;
  logic start_run;
  logic extend;
  logic above_min;
  logic j_last;
  logic push_ok;
  logic emit;
  logic stall;
  logic advance;
  logic tail_take;
  logic push_out;
  logic push_last;
  logic scan_start;

  assign q_hit  = q_data[IDX_BITS+1];
  assign q_last = q_data[IDX_BITS];
  assign q_bin  = q_data[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    rd_data <= hist[mem_raddr];
  end

  always_comb begin
    fall_t     = gt && (sq > SW'(prev));
    rise_t     = lt && (sq > SW'(y));
    fall_n     = fall || fall_t;
    split      = fall_n && rise_t;
    end_run    = in_run && (!y_ge || split);
    start_run  = y_ge && (!in_run || split);
    extend     = in_run && y_ge && !split;
    above_min  = TW'(run_max) > TW'(cfg.peak_min_height);
    j_last     = (NB'(j) + NB'(1)) == n_eff;
    push_ok    = !out_valid || out_ready;
    scan_first = (n_eff == '0) ? htpf_pkg::BS_TAIL : htpf_pkg::BS_READ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htpf_pkg::BS_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_idx;
    mem_wdata  = '0;
    mem_raddr  = j;
    emit       = 1'b0;
    stall      = 1'b0;
    advance    = 1'b0;
    tail_take  = 1'b0;
    push_out   = 1'b0;
    push_last  = 1'b0;
    scan_start = 1'b0;
    unique case (state)
      htpf_pkg::BS_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx == IDX_BITS'(MAX_BINS - 1)) begin
          state_next = htpf_pkg::BS_IDLE;
        end
      end
      htpf_pkg::BS_IDLE: begin
        mem_raddr = q_bin;
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_hit) begin
            state_next = htpf_pkg::BS_INC;
          end else if (q_last) begin
            scan_start = 1'b1;
            state_next = scan_first;
          end
        end
      end
      htpf_pkg::BS_INC: begin
        mem_we    = 1'b1;
        mem_waddr = cur_bin;
        mem_wdata = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
        if (cur_last) begin
          scan_start = 1'b1;
          state_next = scan_first;
        end else begin
          state_next = htpf_pkg::BS_IDLE;
        end
      end
      htpf_pkg::BS_READ: begin
        state_next = htpf_pkg::BS_DIFF;
      end
      htpf_pkg::BS_DIFF: begin
        state_next = htpf_pkg::BS_SQUARE;
      end
      htpf_pkg::BS_SQUARE: begin
        state_next = htpf_pkg::BS_DECIDE;
      end
      htpf_pkg::BS_DECIDE: begin
        emit  = end_run && above_min;
        stall = emit && pend_valid && !push_ok;
        if (!stall) begin
          advance  = 1'b1;
          push_out = emit && pend_valid;
          if (emit && ((found + RB'(1)) == RB'(htpf_pkg::MAX_RESULTS))) begin
            state_next = htpf_pkg::BS_FINISH;
          end else if (j_last) begin
            state_next = htpf_pkg::BS_TAIL;
          end else begin
            state_next = htpf_pkg::BS_READ;
          end
        end
      end
      htpf_pkg::BS_TAIL: begin
        emit  = in_run && above_min;
        stall = emit && pend_valid && !push_ok;
        if (!stall) begin
          tail_take  = 1'b1;
          push_out   = emit && pend_valid;
          state_next = htpf_pkg::BS_FINISH;
        end
      end
      htpf_pkg::BS_FINISH: begin
        if (push_ok) begin
          push_out   = 1'b1;
          push_last  = 1'b1;
          state_next = htpf_pkg::BS_CLEAR;
        end
      end
      default: begin
        state_next = htpf_pkg::BS_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      found      <= '0;
      in_run     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (state == htpf_pkg::BS_CLEAR) begin
        clr_idx <= clr_idx + IDX_BITS'(1);
      end
      if (scan_start) begin
        found      <= '0;
        in_run     <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (advance) begin
        found <= found + RB'(emit);
        if (start_run) begin
          in_run <= 1'b1;
        end else if (end_run) begin
          in_run <= 1'b0;
        end
      end
      if (tail_take) begin
        in_run <= 1'b0;
      end
      if ((advance || tail_take) && emit) begin
        pend_valid <= 1'b1;
      end
      if (push_out && push_last) begin
        pend_valid <= 1'b0;
        clr_idx    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bin  <= q_bin;
      cur_last <= q_last;
    end
    if (scan_start) begin
      j        <= '0;
      bin_time <= OT'(cfg.time_start) + OT'(cfg.bin_width >> 1);
    end
    if (state == htpf_pkg::BS_DIFF) begin
      y    <= rd_data;
      y_ge <= TW'(rd_data) >= TW'(cfg.run_threshold);
      gt   <= prev > rd_data;
      lt   <= rd_data > prev;
      d    <= (prev > rd_data) ? (prev - rd_data) : (rd_data - prev);
    end
    if (state == htpf_pkg::BS_SQUARE) begin
      sq <= SW'(d) * SW'(d);
    end
    if ((advance || tail_take) && emit) begin
      pend_bin  <= htpf_pkg::BIN_OUT_W'(run_max_bin);
      pend_time <= run_max_time;
      pend_h    <= htpf_pkg::HEIGHT_W'(run_max);
    end
    if (advance) begin
      j        <= j + IDX_BITS'(1);
      bin_time <= bin_time + OT'(cfg.bin_width);
      if (start_run) begin
        run_max      <= y;
        run_max_bin  <= j;
        run_max_time <= bin_time;
        prev         <= y;
        fall         <= 1'b0;
      end else if (extend) begin
        if (y > run_max) begin
          run_max      <= y;
          run_max_bin  <= j;
          run_max_time <= bin_time;
        end
        prev <= y;
        fall <= fall_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      if (pend_valid) begin
        peak_valid  <= 1'b1;
        peak_bin    <= pend_bin;
        peak_time   <= pend_time;
        peak_height <= pend_h;
      end else begin
        peak_valid  <= 1'b0;
        peak_bin    <= '0;
        peak_time   <= '0;
        peak_height <= '0;
      end
      last_peak <= push_last;
    end
  end

  `ASSERT_ALWAYS(a_found_bound, clk, rst, found <= RB'(htpf_pkg::MAX_RESULTS))
  `ASSERT_IMPLY(a_pop_when_idle, clk, rst, q_pop, (state == htpf_pkg::BS_IDLE) && !q_empty)
  `ASSERT_IMPLY(a_push_free_slot, clk, rst, push_out, !out_valid || out_ready)

endmodule

`default_nettype wire

// ===== rtl/hit_time_histogram_peak_finder.sv =====
// ----------------------------------------------------------------------------
// Hit time histogram peak finder
// Hits that pass the flag selection and the time window are binned by time
// into a histogram with saturating counters; an item marked last starts a
// scan that reports every run of bins at or above threshold whose top count
// exceeds the minimum height, up to MAX_RESULTS runs, or a single empty
// result, and then clears the histogram. The front end takes a new item only
// once it has dropped the last one or pushed it to the queue; a counted hit
// first passes its two-bit-per-cycle bin divider. The back end does a
// histogram read-modify-write per counted hit, reads, differences, squares
// and decides on each bin in use for the scan, and makes a clearing pass
// over all MAX_BINS bins after each scan and after reset; a four-entry queue
// lets the front end run on meanwhile and holds back its pushes while full.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_time_histogram_peak_finder #(
  parameter int MAX_BINS = 64,
  parameter int COUNT_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [htpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [htpf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [htpf_pkg::TIME_IN_W-1:0]        hit_time,
  input  logic [htpf_pkg::FLAGS_W-1:0]          hit_flags,
  input  logic                                  hit_present,
  input  logic                                  last_hit,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  peak_valid,
  output logic [htpf_pkg::BIN_OUT_W-1:0]        peak_bin,
  output logic [htpf_pkg::TIME_OUT_W-1:0]       peak_time,
  output logic [htpf_pkg::HEIGHT_W-1:0]         peak_height,
  output logic                                  last_peak
);

  localparam int IDX_BITS = $clog2(MAX_BINS);
  localparam int NB = $clog2(MAX_BINS + 1);
  localparam int EW = (NB > htpf_pkg::BINS_W) ? NB : htpf_pkg::BINS_W;

  htpf_pkg::cfg_t                 cfg;
  logic [htpf_pkg::BINS_W-1:0]    bins_used;
  logic [NB-1:0]                  n_eff;
  logic                           q_push;
  logic [IDX_BITS+1:0]            q_wdata;
  logic                           q_full;
  logic                           q_pop;
  logic [IDX_BITS+1:0]            q_rdata;
  logic                           q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_start      <= htpf_pkg::RST_TIME_START;
      cfg.bin_width       <= htpf_pkg::RST_BIN_WIDTH;
      bins_used           <= htpf_pkg::RST_BINS_USED;
      cfg.run_threshold   <= htpf_pkg::RST_RUN_THRESHOLD;
      cfg.peak_min_height <= htpf_pkg::RST_PEAK_MIN_HEIGHT;
      cfg.required_mask   <= '0;
      cfg.position_mask   <= '0;
      cfg.background_mask <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        htpf_pkg::CFG_TIME_START:
          cfg.time_start <= cfg_data[htpf_pkg::TIME_IN_W-1:0];
        htpf_pkg::CFG_BIN_WIDTH:
          cfg.bin_width <= cfg_data[htpf_pkg::WIDTH_W-1:0];
        htpf_pkg::CFG_BINS_USED:
          bins_used <= cfg_data[htpf_pkg::BINS_W-1:0];
        htpf_pkg::CFG_RUN_THRESHOLD:
          cfg.run_threshold <= cfg_data[htpf_pkg::LEVEL_W-1:0];
        htpf_pkg::CFG_PEAK_MIN_HEIGHT:
          cfg.peak_min_height <= cfg_data[htpf_pkg::LEVEL_W-1:0];
        htpf_pkg::CFG_REQUIRED_MASK:
          cfg.required_mask <= cfg_data;
        htpf_pkg::CFG_POSITION_MASK:
          cfg.position_mask <= cfg_data;
        htpf_pkg::CFG_BACKGROUND_MASK:
          cfg.background_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign n_eff = (EW'(bins_used) > EW'(MAX_BINS)) ? NB'(MAX_BINS) : NB'(bins_used);

  htpf_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .n_eff       (n_eff),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .hit_time    (hit_time),
    .hit_flags   (hit_flags),
    .hit_present (hit_present),
    .last_hit    (last_hit),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  htpf_queue #(
    .WIDTH (IDX_BITS + 2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  htpf_back #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .n_eff       (n_eff),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .peak_valid  (peak_valid),
    .peak_bin    (peak_bin),
    .peak_time   (peak_time),
    .peak_height (peak_height),
    .last_peak   (last_peak)
  );

endmodule

`default_nettype wire
